FILE: rtl/core/c8i_pkg.sv
// Shared constants and types of the CHIP-8 instruction core.
`default_nettype none
package c8i_pkg;

  localparam int MemBytes      = 4096;
  localparam int MemAddrW      = 12;
  localparam int ScreenWidth   = 64;
  localparam int ScreenHeight  = 32;
  localparam int RowSelW       = 5;
  localparam int NumRegs       = 16;
  localparam int RegSelW       = 4;
  localparam int StackDepth    = 16;
  localparam int StartAddress  = 512;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

endpackage
`default_nettype wire

FILE: rtl/core/c8i_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none
module c8i_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/core/chip8_instruction_core.sv
// CHIP-8 instruction core: sequencer around program, display, register and stack memories.
//
// One input channel and one output channel, both valid/ready. Each input
// transfer carries an operation: write a memory byte, execute one
// instruction, read one display row, or do nothing. Each one yields exactly one result
// transfer with the display row (read only), the program counter after the
// item and the draw, beep, bad opcode and key wait flags.
// An instruction step fetches two bytes from the program memory, reads two
// registers, executes and updates the timers; 00EE reads the return address
// in a further state, the flag-setting 8XYN forms write VX after VF, 00E0
// clears every display row, DXYN reads and rewrites each sprite row and then
// writes VF, FX55 and FX65 move one register at a time and FX33 writes three
// BCD digits to memory.
// One item is processed at a time. A finished result sits in the output
// register while the next item is taken; if the receiver stalls, the core
// holds the following result until the output register is free.
// After reset the core sweeps the 4096-byte program memory (and the display,
// register and stack memories) to zero, one entry per cycle; in_ready_o stays
// low during that sweep.
`default_nettype none
module chip8_instruction_core #(
  parameter int STACK_DEPTH   = c8i_pkg::StackDepth,
  parameter int START_ADDRESS = c8i_pkg::StartAddress
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [15:0] keys_i,
  input  wire logic [7:0]  random_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      display_row_o,
  output logic [11:0]      program_counter_o,
  output logic             draw_o,
  output logic             beep_o,
  output logic             bad_opcode_o,
  output logic             key_wait_o
);

  localparam int AW  = c8i_pkg::MemAddrW;
  localparam int RW  = c8i_pkg::RowSelW;
  localparam int SW  = c8i_pkg::ScreenWidth;
  localparam int GW  = c8i_pkg::RegSelW;
  localparam int SpW = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WRMEM, S_RDROW, S_RDROW2, S_F1, S_F2, S_F3, S_D2, S_D3,
    S_EXE, S_VXW, S_RET, S_CLS, S_DRA, S_DRB, S_DRF, S_BCD, S_STA, S_STB,
    S_LDA, S_LDB, S_STEP, S_FIN
  } state_e;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } mem_wr_t;

  typedef struct packed {
    logic          en;
    logic [RW-1:0] addr;
    logic [SW-1:0] data;
  } frame_wr_t;

  typedef struct packed {
    logic          en;
    logic [GW-1:0] addr;
    logic [7:0]    data;
  } reg_wr_t;

  typedef struct packed {
    logic           en;
    logic [SpW-1:0] addr;
    logic [AW-1:0]  data;
  } stack_wr_t;

  state_e          state_q;
  logic [AW-1:0]   addr_q;
  logic [7:0]      wdata_q;
  logic [15:0]     keys_q;
  logic [7:0]      rnd_q;
  logic [7:0]      hi_q, lo_q, vx_q, vy_q, tmp_q;
  logic [AW-1:0]   next_q, pc_q, i_q;
  logic [SpW-1:0]  sp_q;
  logic [7:0]      dt_q, st_q;
  logic [AW-1:0]   cnt_q;
  logic            hit_q, draw_q, beep_q, bad_q, wait_q;
  logic [SW-1:0]   row_q;
  logic            out_valid_q;

  mem_wr_t         mw_q;
  frame_wr_t       fw_q;
  reg_wr_t         rw_q;
  stack_wr_t       sw_q;

  logic [AW-1:0]   mem_raddr;
  logic [RW-1:0]   frame_raddr;
  logic [GW-1:0]   reg_raddr;
  logic [SpW-1:0]  stack_raddr;
  logic [7:0]      mem_rdata;
  logic [SW-1:0]   frame_rdata;
  logic [7:0]      reg_rdata;
  logic [AW-1:0]   stack_rdata;

  logic [3:0]      grp, xs, ys, ns;
  logic [7:0]      nn;
  logic [AW-1:0]   nnn;
  logic [SpW-1:0]  sp_inc, sp_dec;
  logic [8:0]      add9;
  logic [AW:0]     iadd;
  logic [RW-1:0]   draw_row;
  logic [SW-1:0]   sprite_mask;
  logic [3:0]      key_hi;
  logic            key_hit;
  logic [7:0]      rnd_mod;
  logic [7:0]      bcd_digit;

  assign grp = hi_q[7:4];
  assign xs  = hi_q[3:0];
  assign ys  = lo_q[7:4];
  assign ns  = lo_q[3:0];
  assign nn  = lo_q;
  assign nnn = {hi_q[3:0], lo_q};

  assign sp_inc = (sp_q == SpW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SpW'(STACK_DEPTH - 1) : sp_q - 1'b1;

  assign add9     = {1'b0, vx_q} + {1'b0, vy_q};
  assign iadd     = {1'b0, i_q} + {5'b0, vx_q};
  assign draw_row = vy_q[RW-1:0] + cnt_q[RW-1:0];
  assign rnd_mod  = (rnd_q == 8'hFF) ? 8'h00 : rnd_q;
  assign key_hit  = (vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]];

  // Sprite byte placed at the left edge, then rotated right so that the
  // columns wrap around the screen.
  function automatic logic [SW-1:0] sprite_rot(input logic [7:0] bits, input logic [5:0] sh);
    logic [SW-1:0] s;
    logic [6:0]    back;
    s    = {bits, {(SW-8){1'b0}}};
    back = 7'd64 - {1'b0, sh};
    return (s >> sh) | (s << back);
  endfunction

  assign sprite_mask = sprite_rot(mem_rdata, vx_q[5:0]);

  always_comb begin
    key_hi = 4'h0;
    for (int k = 0; k < 16; k++) begin
      if (keys_q[k]) begin
        key_hi = 4'(k);
      end
    end
  end

  // Decimal digit of VX selected by the counter: hundreds, tens, ones.
  always_comb begin
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    h = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
    r = vx_q - (8'd100 * {6'b0, h});
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(10 * k)) begin
        t = 4'(k);
      end
    end
    case (cnt_q[1:0])
      2'd0:    bcd_digit = {6'b0, h};
      2'd1:    bcd_digit = {4'b0, t};
      default: bcd_digit = r - (8'd10 * {4'b0, t});
    endcase
  end

  always_comb begin
    mem_raddr   = '0;
    frame_raddr = '0;
    reg_raddr   = '0;
    stack_raddr = '0;
    case (state_q)
      S_F1:    mem_raddr = pc_q;
      S_F2:    mem_raddr = pc_q + 12'd1;
      S_F3:    reg_raddr = (hi_q[7:4] == 4'hB) ? 4'h0 : hi_q[3:0];
      S_D2:    reg_raddr = ys;
      S_EXE:   stack_raddr = sp_dec;
      S_RDROW: frame_raddr = addr_q[RW-1:0];
      S_DRA: begin
        mem_raddr   = i_q + {8'b0, cnt_q[3:0]};
        frame_raddr = draw_row;
      end
      S_STA:   reg_raddr = cnt_q[3:0];
      S_LDA:   mem_raddr = i_q + {8'b0, cnt_q[3:0]};
      default: ;
    endcase
  end

  c8i_ram #(.WIDTH(8), .DEPTH(c8i_pkg::MemBytes)) u_prog_mem (
    .clk_i   (clk_i),
    .we_i    (mw_q.en),
    .waddr_i (mw_q.addr),
    .wdata_i (mw_q.data),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  c8i_ram #(.WIDTH(SW), .DEPTH(c8i_pkg::ScreenHeight)) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (fw_q.en),
    .waddr_i (fw_q.addr),
    .wdata_i (fw_q.data),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  c8i_ram #(.WIDTH(8), .DEPTH(c8i_pkg::NumRegs)) u_reg_mem (
    .clk_i   (clk_i),
    .we_i    (rw_q.en),
    .waddr_i (rw_q.addr),
    .wdata_i (rw_q.data),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  c8i_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (sw_q.en),
    .waddr_i (sw_q.addr),
    .wdata_i (sw_q.data),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      addr_q            <= '0;
      wdata_q           <= '0;
      keys_q            <= '0;
      rnd_q             <= '0;
      hi_q              <= '0;
      lo_q              <= '0;
      vx_q              <= '0;
      vy_q              <= '0;
      tmp_q             <= '0;
      next_q            <= '0;
      pc_q              <= AW'(START_ADDRESS);
      i_q               <= '0;
      sp_q              <= '0;
      dt_q              <= '0;
      st_q              <= '0;
      cnt_q             <= '0;
      hit_q             <= 1'b0;
      draw_q            <= 1'b0;
      beep_q            <= 1'b0;
      bad_q             <= 1'b0;
      wait_q            <= 1'b0;
      row_q             <= '0;
      out_valid_q       <= 1'b0;
      display_row_o     <= '0;
      program_counter_o <= '0;
      draw_o            <= 1'b0;
      beep_o            <= 1'b0;
      bad_opcode_o      <= 1'b0;
      key_wait_o        <= 1'b0;
      mw_q              <= '0;
      fw_q              <= '0;
      rw_q              <= '0;
      sw_q              <= '0;
    end else begin
      mw_q.en <= 1'b0;
      fw_q.en <= 1'b0;
      rw_q.en <= 1'b0;
      sw_q.en <= 1'b0;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          mw_q <= '{en: 1'b1, addr: cnt_q, data: 8'h00};
          fw_q <= '{en: (cnt_q < 12'(c8i_pkg::ScreenHeight)), addr: cnt_q[RW-1:0], data: '0};
          rw_q <= '{en: (cnt_q < 12'(c8i_pkg::NumRegs)), addr: cnt_q[GW-1:0], data: 8'h00};
          sw_q <= '{en: (cnt_q < 12'(STACK_DEPTH)), addr: cnt_q[SpW-1:0], data: '0};
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q == 12'hFFF) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            addr_q  <= address_i;
            wdata_q <= write_data_i;
            keys_q  <= keys_i;
            rnd_q   <= random_byte_i;
            draw_q  <= 1'b0;
            beep_q  <= 1'b0;
            bad_q   <= 1'b0;
            wait_q  <= 1'b0;
            row_q   <= '0;
            unique case (c8i_pkg::op_e'(operation_i))
              c8i_pkg::OP_WRITE: state_q <= S_WRMEM;
              c8i_pkg::OP_READ:  state_q <= S_RDROW;
              c8i_pkg::OP_STEP:  state_q <= S_F1;
              default:           state_q <= S_FIN;
            endcase
          end
        end
        S_WRMEM: begin
          mw_q    <= '{en: 1'b1, addr: addr_q, data: wdata_q};
          state_q <= S_FIN;
        end
        S_RDROW:  state_q <= S_RDROW2;
        S_RDROW2: begin
          row_q   <= frame_rdata;
          state_q <= S_FIN;
        end
        S_F1: state_q <= S_F2;
        S_F2: begin
          hi_q    <= mem_rdata;
          state_q <= S_F3;
        end
        S_F3: begin
          lo_q    <= mem_rdata;
          state_q <= S_D2;
        end
        S_D2: begin
          vx_q    <= reg_rdata;
          state_q <= S_D3;
        end
        S_D3: begin
          vy_q    <= reg_rdata;
          state_q <= S_EXE;
        end
        S_EXE: begin
          next_q  <= pc_q + 12'd2;
          cnt_q   <= '0;
          state_q <= S_STEP;
          unique case (grp)
            4'h0: begin
              if ({hi_q, lo_q} == 16'h00E0) begin
                draw_q  <= 1'b1;
                state_q <= S_CLS;
              end else if ({hi_q, lo_q} == 16'h00EE) begin
                sp_q    <= sp_dec;
                state_q <= S_RET;
              end else begin
                bad_q <= 1'b1;
              end
            end
            4'h1: next_q <= nnn;
            4'h2: begin
              sw_q   <= '{en: 1'b1, addr: sp_q, data: pc_q};
              sp_q   <= sp_inc;
              next_q <= nnn;
            end
            4'h3: if (vx_q == nn) next_q <= pc_q + 12'd4;
            4'h4: if (vx_q != nn) next_q <= pc_q + 12'd4;
            4'h5: if (vx_q == vy_q) next_q <= pc_q + 12'd4;
            4'h9: if (vx_q != vy_q) next_q <= pc_q + 12'd4;
            4'h6: rw_q <= '{en: 1'b1, addr: xs, data: nn};
            4'h7: rw_q <= '{en: 1'b1, addr: xs, data: vx_q + nn};
            4'h8: begin
              // Flag goes to VF first; VX is written in the next cycle, so it wins when X is F.
              case (ns)
                4'h0: rw_q <= '{en: 1'b1, addr: xs, data: vy_q};
                4'h1: rw_q <= '{en: 1'b1, addr: xs, data: vx_q | vy_q};
                4'h2: rw_q <= '{en: 1'b1, addr: xs, data: vx_q & vy_q};
                4'h3: rw_q <= '{en: 1'b1, addr: xs, data: vx_q ^ vy_q};
                4'h4: begin
                  rw_q    <= '{en: 1'b1, addr: 4'hF, data: {7'b0, add9[8]}};
                  tmp_q   <= add9[7:0];
                  state_q <= S_VXW;
                end
                4'h5: begin
                  rw_q    <= '{en: 1'b1, addr: 4'hF, data: {7'b0, !(vy_q > vx_q)}};
                  tmp_q   <= vx_q - vy_q;
                  state_q <= S_VXW;
                end
                4'h6: begin
                  rw_q    <= '{en: 1'b1, addr: 4'hF, data: {7'b0, vx_q[0]}};
                  tmp_q   <= {1'b0, vx_q[7:1]};
                  state_q <= S_VXW;
                end
                4'h7: begin
                  rw_q    <= '{en: 1'b1, addr: 4'hF, data: {7'b0, !(vx_q > vy_q)}};
                  tmp_q   <= vy_q - vx_q;
                  state_q <= S_VXW;
                end
                4'hE: begin
                  rw_q    <= '{en: 1'b1, addr: 4'hF, data: {7'b0, vx_q[7]}};
                  tmp_q   <= {vx_q[6:0], 1'b0};
                  state_q <= S_VXW;
                end
                default: bad_q <= 1'b1;
              endcase
            end
            4'hA: i_q <= nnn;
            4'hB: next_q <= nnn + {4'b0, vx_q};
            4'hC: rw_q <= '{en: 1'b1, addr: xs, data: rnd_mod & nn};
            4'hD: begin
              draw_q <= 1'b1;
              hit_q  <= 1'b0;
              if (ns == 4'h0) begin
                rw_q <= '{en: 1'b1, addr: 4'hF, data: 8'h00};
              end else begin
                state_q <= S_DRA;
              end
            end
            4'hE: begin
              if (nn == 8'h9E) begin
                if (key_hit) next_q <= pc_q + 12'd4;
              end else if (nn == 8'hA1) begin
                if (!key_hit) next_q <= pc_q + 12'd4;
              end else begin
                bad_q <= 1'b1;
              end
            end
            default: begin
              case (nn)
                8'h07: rw_q <= '{en: 1'b1, addr: xs, data: dt_q};
                8'h0A: begin
                  if (keys_q == 16'h0000) begin
                    wait_q <= 1'b1;
                  end else begin
                    rw_q <= '{en: 1'b1, addr: xs, data: {4'b0, key_hi}};
                  end
                end
                8'h15: dt_q <= vx_q;
                8'h18: st_q <= vx_q;
                8'h1E: begin
                  rw_q <= '{en: 1'b1, addr: 4'hF, data: {7'b0, iadd[AW]}};
                  i_q  <= iadd[AW-1:0];
                end
                8'h29: i_q <= {2'b0, vx_q, 2'b0} + {4'b0, vx_q};
                8'h33: state_q <= S_BCD;
                8'h55: state_q <= S_STA;
                8'h65: state_q <= S_LDA;
                default: bad_q <= 1'b1;
              endcase
            end
          endcase
        end
        S_VXW: begin
          rw_q    <= '{en: 1'b1, addr: xs, data: tmp_q};
          state_q <= S_STEP;
        end
        S_RET: begin
          next_q  <= stack_rdata + 12'd2;
          state_q <= S_STEP;
        end
        S_CLS: begin
          fw_q  <= '{en: 1'b1, addr: cnt_q[RW-1:0], data: '0};
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q[RW-1:0] == RW'(c8i_pkg::ScreenHeight - 1)) begin
            state_q <= S_STEP;
          end
        end
        S_DRA: state_q <= S_DRB;
        S_DRB: begin
          fw_q  <= '{en: 1'b1, addr: draw_row, data: frame_rdata ^ sprite_mask};
          hit_q <= hit_q | (|(frame_rdata & sprite_mask));
          cnt_q <= cnt_q + 12'd1;
          state_q <= (cnt_q[3:0] == ns - 4'd1) ? S_DRF : S_DRA;
        end
        S_DRF: begin
          rw_q    <= '{en: 1'b1, addr: 4'hF, data: {7'b0, hit_q}};
          state_q <= S_STEP;
        end
        S_BCD: begin
          mw_q  <= '{en: 1'b1, addr: i_q + cnt_q, data: bcd_digit};
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q[1:0] == 2'd2) begin
            state_q <= S_STEP;
          end
        end
        S_STA: state_q <= S_STB;
        S_STB: begin
          mw_q  <= '{en: 1'b1, addr: i_q + {8'b0, cnt_q[3:0]}, data: reg_rdata};
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q[3:0] == xs) begin
            i_q     <= i_q + {8'b0, xs} + 12'd1;
            state_q <= S_STEP;
          end else begin
            state_q <= S_STA;
          end
        end
        S_LDA: state_q <= S_LDB;
        S_LDB: begin
          rw_q  <= '{en: 1'b1, addr: cnt_q[3:0], data: mem_rdata};
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q[3:0] == xs) begin
            i_q     <= i_q + {8'b0, xs} + 12'd1;
            state_q <= S_STEP;
          end else begin
            state_q <= S_LDA;
          end
        end
        S_STEP: begin
          if (!wait_q) begin
            if (!bad_q) begin
              pc_q <= next_q;
            end
            if (dt_q != 8'h00) begin
              dt_q <= dt_q - 8'd1;
            end
            if (st_q != 8'h00) begin
              st_q <= st_q - 8'd1;
            end
            beep_q <= (st_q == 8'h01);
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            display_row_o     <= row_q;
            program_counter_o <= pc_q;
            draw_o            <= draw_q;
            beep_o            <= beep_q;
            bad_opcode_o      <= bad_q;
            key_wait_o        <= wait_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
